[src/acs_pkg.sv]
// acs_pkg: shared types and constants for the affinity chunk scheduler.
// Request/result payload structs, register map and reset values.
// No dependencies.
package acs_pkg;

  localparam int MAX_WORKERS_DEF = 16;
  localparam int ITER_BITS_DEF   = 24;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_WORKER_COUNT     = 1'b0;
  localparam logic REG_TOTAL_ITERATIONS = 1'b1;

  localparam logic [4:0]  WORKER_COUNT_RST     = 5'd4;
  localparam logic [23:0] TOTAL_ITERATIONS_RST = 24'd1024;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic       action;
    logic [3:0] worker_id;
  } item_t;

  typedef struct packed {
    logic [23:0] chunk_start;
    logic [23:0] chunk_end;
    logic [3:0]  source_worker;
    logic        done_res;
  } result_t;

  typedef struct packed {
    logic [4:0]  worker_count;
    logic [23:0] total_iterations;
  } cfg_t;

  localparam result_t RESULT_DONE = '{
    chunk_start:   24'd0,
    chunk_end:     24'd0,
    source_worker: 4'd0,
    done_res:      1'b1
  };

endpackage

[src/acs_ram.sv]
// acs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module acs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/acs_div.sv]
// acs_div: iterative restoring divider, one quotient bit per cycle.
// Returns the ceiling quotient. No dependencies.
module acs_div #(
  parameter int IB = 24,
  parameter int PW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [IB-1:0] dividend,
  input  logic [PW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [IB-1:0] quot
);

  localparam int CNT_W = $clog2(IB + 1);

  logic [IB-1:0]    quo;
  logic [PW-1:0]    rem;
  logic [PW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic [PW:0]      rem_sh;
  logic [PW:0]      rem_sub;
  logic             ge;

  assign rem_sh  = {rem, quo[IB-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign quot    = quo + IB'(rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= CNT_W'(IB);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem <= ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
      quo <= {quo[IB-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[src/acs_regs.sv]
// acs_regs: APB-style configuration registers (worker count, iteration count).
// Depends on acs_pkg.
module acs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [acs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [acs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output acs_pkg::cfg_t                 cfg
);

  import acs_pkg::*;

  logic reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.worker_count     <= WORKER_COUNT_RST;
      cfg.total_iterations <= TOTAL_ITERATIONS_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WORKER_COUNT:     cfg.worker_count     <= pwdata[4:0];
        REG_TOTAL_ITERATIONS: cfg.total_iterations <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WORKER_COUNT:     prdata = CFG_DATA_W'(cfg.worker_count);
      REG_TOTAL_ITERATIONS: prdata = CFG_DATA_W'(cfg.total_iterations);
      default:              prdata = '0;
    endcase
  end

endmodule

[src/affinity_chunk_scheduler_core.sv]
// affinity_chunk_scheduler_core: affinity loop scheduler with work stealing.
// Depends on acs_pkg, acs_regs, acs_div, acs_ram.
//
//   channel  | signals                          | carries
//   ---------+----------------------------------+-----------------------------
//   item     | item_valid, item_stall, item     | start or chunk request
//   result   | result_valid, result_stall, result | chunk bounds or done
//   config   | psel/penable/pwrite/paddr/...    | worker_count, total_iterations
//
// Start: divider computes the per-worker share, then one range write per cycle.
// Request, own range: read, check and divide; stealing adds a scan of every range.
// A request before any start returns done. All divisions share one bit-serial divider.
// Reset is synchronous; range memory holds no reset value and is written by a start.
// The item side stalls while a request is in progress; one result is held in the
// output register, so a stalled result delays only the next completion.
module affinity_chunk_scheduler_core #(
  parameter int MAX_WORKERS = acs_pkg::MAX_WORKERS_DEF,
  parameter int ITER_BITS   = acs_pkg::ITER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  acs_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output acs_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [acs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [acs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  import acs_pkg::*;

  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam int IB = ITER_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_PER, S_FILL, S_OWN_RD, S_OWN_CHK,
    S_SCAN, S_PICK, S_DIV_TAKE, S_DONE
  } state_t;

  state_t        state;
  cfg_t          cfg;
  logic [3:0]    wid_r;
  logic          started;
  logic [CW-1:0] cnt;
  logic [IB:0]   run;
  logic [IB-1:0] per;
  logic [IB-1:0] best;
  logic [AW-1:0] src;
  logic [IB-1:0] lo_sel;
  logic [IB-1:0] hi_sel;
  logic          scan_vld;
  logic [AW-1:0] scan_idx;
  result_t       res;

  logic [CW-1:0]   p_eff;
  logic [IB-1:0]   n_eff;
  logic            div_start;
  logic [IB-1:0]   div_a;
  logic            div_busy;
  logic            div_done;
  logic [IB-1:0]   div_q;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [2*IB-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [2*IB-1:0] ram_rdata;
  logic [IB-1:0]   ram_lo;
  logic [IB-1:0]   ram_hi;
  logic            has_work;
  logic [IB-1:0]   avail;
  logic [IB:0]     run_hi;
  logic [IB-1:0]   fill_lo;
  logic [IB-1:0]   fill_hi;
  logic            fill_used;
  logic [IB-1:0]   new_lo;
  logic            wid_ok;

  acs_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  acs_div #(.IB(IB), .PW(CW)) u_div (
    .clk, .rst,
    .start    (div_start),
    .dividend (div_a),
    .divisor  (p_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  acs_ram #(.WIDTH(2 * IB), .DEPTH(MAX_WORKERS), .AW(AW)) u_ranges (
    .clk,
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (cfg.worker_count == 5'd0) begin
      p_eff = CW'(1);
    end else if (32'(cfg.worker_count) > MAX_WORKERS) begin
      p_eff = CW'(MAX_WORKERS);
    end else begin
      p_eff = CW'(cfg.worker_count);
    end
  end

  assign n_eff      = IB'(cfg.total_iterations);
  assign item_stall = (state != S_IDLE);
  assign wid_ok     = 32'(wid_r) < MAX_WORKERS;

  assign ram_lo   = ram_rdata[IB-1:0];
  assign ram_hi   = ram_rdata[2*IB-1:IB];
  assign has_work = ram_hi > ram_lo;
  assign avail    = has_work ? (ram_hi - ram_lo) : '0;

  assign run_hi    = run + {1'b0, per};
  assign fill_lo   = (run > {1'b0, n_eff}) ? n_eff : run[IB-1:0];
  assign fill_hi   = (run_hi > {1'b0, n_eff}) ? n_eff : run_hi[IB-1:0];
  assign fill_used = 32'(cnt) < 32'(p_eff);
  assign new_lo    = lo_sel + div_q;

  assign ram_raddr = (state == S_OWN_RD) ? AW'(wid_r) : cnt[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = '0;
    if (state == S_FILL) begin
      ram_we    = 1'b1;
      ram_wdata = fill_used ? {fill_hi, fill_lo} : '0;
    end else if (state == S_DIV_TAKE && div_done) begin
      ram_we    = 1'b1;
      ram_waddr = src;
      ram_wdata = {hi_sel, new_lo};
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = n_eff;
    if (state == S_IDLE && item_valid && item.action == ACT_START) begin
      div_start = 1'b1;
    end else if (state == S_OWN_CHK && has_work) begin
      div_start = 1'b1;
      div_a     = avail;
    end else if (state == S_PICK && best != '0) begin
      div_start = 1'b1;
      div_a     = best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      started      <= 1'b0;
      result_valid <= 1'b0;
      scan_vld     <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            wid_r <= item.worker_id;
            if (item.action == ACT_START) begin
              state <= S_DIV_PER;
            end else if (!started) begin
              res   <= RESULT_DONE;
              state <= S_DONE;
            end else begin
              state <= S_OWN_RD;
            end
          end
        end
        S_DIV_PER: begin
          if (div_done) begin
            per   <= div_q;
            run   <= '0;
            cnt   <= '0;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_used) begin
            run <= run_hi;
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(MAX_WORKERS - 1)) begin
            started <= 1'b1;
            res     <= RESULT_DONE;
            state   <= S_DONE;
          end
        end
        S_OWN_RD: begin
          if (wid_ok) begin
            state <= S_OWN_CHK;
          end else begin
            cnt      <= '0;
            scan_vld <= 1'b0;
            best     <= '0;
            src      <= '0;
            state    <= S_SCAN;
          end
        end
        S_OWN_CHK: begin
          if (has_work) begin
            best   <= avail;
            src    <= AW'(wid_r);
            lo_sel <= ram_lo;
            hi_sel <= ram_hi;
            state  <= S_DIV_TAKE;
          end else begin
            cnt      <= '0;
            scan_vld <= 1'b0;
            best     <= '0;
            src      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_vld && avail > best) begin
            best   <= avail;
            src    <= scan_idx;
            lo_sel <= ram_lo;
            hi_sel <= ram_hi;
          end
          if (cnt != CW'(MAX_WORKERS)) begin
            scan_vld <= 1'b1;
            scan_idx <= cnt[AW-1:0];
            cnt      <= cnt + 1'b1;
          end else begin
            scan_vld <= 1'b0;
            state    <= S_PICK;
          end
        end
        S_PICK: begin
          if (best != '0) begin
            state <= S_DIV_TAKE;
          end else begin
            res   <= RESULT_DONE;
            state <= S_DONE;
          end
        end
        S_DIV_TAKE: begin
          if (div_done) begin
            res.chunk_start   <= 24'(lo_sel);
            res.chunk_end     <= 24'(new_lo);
            res.source_worker <= 4'(src);
            res.done_res      <= 1'b0;
            state             <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_ram_we: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_FILL || state == S_DIV_TAKE))
    else $error("range write outside fill or grant");

  a_grant_span: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.done_res) |-> (result.chunk_end > result.chunk_start))
    else $error("granted chunk is empty");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.done_res) |->
      (result.chunk_start == '0 && result.chunk_end == '0 && result.source_worker == '0))
    else $error("done result carries bounds");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

endmodule
